// ===== design/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types, codes and defaults of the correlation matrix accumulator.
// ----------------------------------------------------------------------------
package cma_pkg;

    // Defaults for the top-level parameters
    localparam int MaxFeatures = 32;
    localparam int SampleWidth = 16;
    localparam int AccWidth    = 48;

    // Fixed field widths
    localparam int OpWidth   = 2;
    localparam int PortIdxW  = 6;
    localparam int CfgWidth  = 6;
    localparam int DampWidth = 16;
    localparam int DampFrac  = 15;

    // Internal index width (holds 0..64) and sweep counter width (65*65 entries)
    localparam int IdxW   = 7;
    localparam int SweepW = 13;

    localparam logic [CfgWidth-1:0] FeatureCountReset = 6'd32;

    // Operation codes
    localparam logic [OpWidth-1:0] OP_LOAD  = 2'd0;
    localparam logic [OpWidth-1:0] OP_DAMP  = 2'd1;
    localparam logic [OpWidth-1:0] OP_READ  = 2'd2;
    localparam logic [OpWidth-1:0] OP_CLEAR = 2'd3;

    // Result kinds
    localparam logic [OpWidth-1:0] KIND_UPDATE = 2'd0;
    localparam logic [OpWidth-1:0] KIND_DAMP   = 2'd1;
    localparam logic [OpWidth-1:0] KIND_READ   = 2'd2;
    localparam logic [OpWidth-1:0] KIND_CLEAR  = 2'd3;

    // Matrix address sources
    localparam logic [1:0] ADDR_RC    = 2'd0;
    localparam logic [1:0] ADDR_CR    = 2'd1;
    localparam logic [1:0] ADDR_SWEEP = 2'd2;

    // Matrix write data sources
    localparam logic [1:0] WD_ZERO = 2'd0;
    localparam logic [1:0] WD_RE   = 2'd1;
    localparam logic [1:0] WD_IM   = 2'd2;
    localparam logic [1:0] WD_DAMP = 2'd3;

    typedef struct packed {
        logic                vec_we;
        logic                vec_rd_row;
        logic                xr_load;
        logic                prod_load;
        logic                cap_a;
        logic                cap_b;
        logic                cap_val;
        logic                damp_cap;
        logic                damp_load;
        logic                mat_we;
        logic [1:0]          rd_sel;
        logic [1:0]          wr_sel;
        logic [1:0]          wdata_sel;
        logic [IdxW-1:0]     row;
        logic [IdxW-1:0]     col;
        logic [SweepW-1:0]   sweep;
        logic                out_load;
        logic                out_zero;
        logic [OpWidth-1:0]  kind;
    } t_cmd;

    typedef struct packed {
        logic [IdxW-1:0] feature_count;
    } t_status;

endpackage

// ===== design/correlation_matrix_accumulator.sv =====
// ----------------------------------------------------------------------------
// correlation_matrix_accumulator
// Complex autocorrelation matrix accumulator with damping, read and clear.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------
//  input     | in        | i_valid / o_ready         | op, index, samples, damp, row/col
//  result    | out       | o_valid / i_ready         | result_kind, entry_value
//  config    | in        | i_cfg_valid / o_cfg_ready | feature_count
//
//  A plain load only writes the vector buffer and gives no result. An update
//  fetches the element of each row, then reads, multiplies and writes back
//  each of the F(F+3)/2 upper-triangle entries, real then imaginary part in
//  turn, through the single write port of the matrix memory. Damping reads,
//  scales and writes back every entry, clear zeroes every entry; both then
//  load the result register, as a read does after S_RD and S_RDL. After reset
//  a clearing pass zeroes every entry before the first transfer is taken. A
//  stalled result holds in its register; the next item is still taken.
// ----------------------------------------------------------------------------
module correlation_matrix_accumulator #(
    parameter int MAX_FEATURES = cma_pkg::MaxFeatures,
    parameter int SAMPLE_WIDTH = cma_pkg::SampleWidth,
    parameter int ACC_WIDTH    = cma_pkg::AccWidth
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cma_pkg::CfgWidth-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [cma_pkg::OpWidth-1:0]        i_op,
    input  logic [cma_pkg::PortIdxW-1:0]       i_element_index,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_im,
    input  logic [cma_pkg::DampWidth-1:0]      i_damping_factor,
    input  logic [cma_pkg::PortIdxW-1:0]       i_read_row,
    input  logic [cma_pkg::PortIdxW-1:0]       i_read_col,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [cma_pkg::OpWidth-1:0]        o_result_kind,
    output logic signed [ACC_WIDTH-1:0]        o_entry_value
);

    cma_pkg::t_cmd    cmd;
    cma_pkg::t_status status;

    // Always ready; the source must write only with nothing in flight; unchecked here
    assign o_cfg_ready = 1'b1;

    cma_ctrl #(.MAX_FEATURES(MAX_FEATURES)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_element_index (i_element_index),
        .i_read_row      (i_read_row),
        .i_read_col      (i_read_col),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    cma_datapath #(
        .MAX_FEATURES (MAX_FEATURES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_element_index  (i_element_index),
        .i_sample_re      (i_sample_re),
        .i_sample_im      (i_sample_im),
        .i_damping_factor (i_damping_factor),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_result_kind    (o_result_kind),
        .o_entry_value    (o_entry_value)
    );

endmodule

// ===== design/cma_ram.sv =====
// ----------------------------------------------------------------------------
// cma_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cma_ctrl.sv =====
// ----------------------------------------------------------------------------
// cma_ctrl
// Controller: sequences loads, triangle updates, damping, reads and clears.
// ----------------------------------------------------------------------------
module cma_ctrl #(
    parameter int MAX_FEATURES = cma_pkg::MaxFeatures
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cma_pkg::OpWidth-1:0]   i_op,
    input  logic [cma_pkg::PortIdxW-1:0]  i_element_index,
    input  logic [cma_pkg::PortIdxW-1:0]  i_read_row,
    input  logic [cma_pkg::PortIdxW-1:0]  i_read_col,
    output logic                          o_valid,
    input  logic                          i_ready,
    input  cma_pkg::t_status              i_status,
    output cma_pkg::t_cmd                 o_cmd
);

    localparam int Dim     = MAX_FEATURES + 1;
    localparam int Entries = Dim * Dim;
    localparam logic [cma_pkg::SweepW-1:0] LastEntry = cma_pkg::SweepW'(Entries - 1);
    localparam logic [cma_pkg::IdxW-1:0]   MaxIdx    = cma_pkg::IdxW'(MAX_FEATURES);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLR    = 4'd2;
    localparam logic [3:0] S_ROW    = 4'd3;
    localparam logic [3:0] S_ROWL   = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_MUL = 4'd6;
    localparam logic [3:0] S_UP_WRE = 4'd7;
    localparam logic [3:0] S_UP_WRI = 4'd8;
    localparam logic [3:0] S_DM_RD  = 4'd9;
    localparam logic [3:0] S_DM_MUL = 4'd10;
    localparam logic [3:0] S_DM_WR  = 4'd11;
    localparam logic [3:0] S_RD     = 4'd12;
    localparam logic [3:0] S_RDL    = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0]                   r_state, n_state;
    logic [cma_pkg::IdxW-1:0]     r_row, n_row;
    logic [cma_pkg::IdxW-1:0]     r_col, n_col;
    logic [cma_pkg::SweepW-1:0]   r_sweep, n_sweep;
    logic [cma_pkg::OpWidth-1:0]  r_kind, n_kind;
    logic                         r_oob, n_oob;
    logic                         r_out_valid, n_out_valid;

    logic                         accept;
    logic [cma_pkg::IdxW-1:0]     idx_ext, row_ext, col_ext, fcnt;
    logic                         rd_oob;
    cma_pkg::t_cmd                cmd;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign idx_ext = {1'b0, i_element_index};
    assign row_ext = {1'b0, i_read_row};
    assign col_ext = {1'b0, i_read_col};
    assign fcnt    = i_status.feature_count;
    assign rd_oob  = (row_ext > MaxIdx) || (col_ext > MaxIdx);

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_sweep     = r_sweep;
        n_kind      = r_kind;
        n_oob       = r_oob;
        cmd         = '0;
        cmd.row     = r_row;
        cmd.col     = r_col;
        cmd.sweep   = r_sweep;
        cmd.kind    = r_kind;
        cmd.out_zero = (r_kind != cma_pkg::KIND_READ) || r_oob;
        cmd.vec_we  = accept && (i_op == cma_pkg::OP_LOAD) && (idx_ext <= fcnt);
        case (r_state)
            S_INIT, S_CLR: begin
                cmd.mat_we    = 1'b1;
                cmd.wr_sel    = cma_pkg::ADDR_SWEEP;
                cmd.wdata_sel = cma_pkg::WD_ZERO;
                if (r_sweep == LastEntry) begin
                    n_sweep = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_sweep = r_sweep + cma_pkg::SweepW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_op)
                        cma_pkg::OP_LOAD: begin
                            if (idx_ext == fcnt) begin
                                n_kind  = cma_pkg::KIND_UPDATE;
                                n_row   = '0;
                                n_col   = '0;
                                n_state = S_ROW;
                            end
                        end
                        cma_pkg::OP_DAMP: begin
                            cmd.damp_cap = 1'b1;
                            n_kind  = cma_pkg::KIND_DAMP;
                            n_sweep = '0;
                            n_state = S_DM_RD;
                        end
                        cma_pkg::OP_READ: begin
                            n_kind  = cma_pkg::KIND_READ;
                            n_oob   = rd_oob;
                            n_row   = rd_oob ? '0 : row_ext;
                            n_col   = rd_oob ? '0 : col_ext;
                            n_state = S_RD;
                        end
                        default: begin
                            n_kind  = cma_pkg::KIND_CLEAR;
                            n_sweep = '0;
                            n_state = S_CLR;
                        end
                    endcase
                end
            end
            S_ROW: begin
                cmd.vec_rd_row = 1'b1;
                n_state = S_ROWL;
            end
            S_ROWL: begin
                cmd.xr_load = 1'b1;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                cmd.rd_sel = cma_pkg::ADDR_RC;
                n_state = S_UP_MUL;
            end
            S_UP_MUL: begin
                cmd.prod_load = 1'b1;
                cmd.cap_a     = 1'b1;
                cmd.rd_sel    = cma_pkg::ADDR_CR;
                n_state = S_UP_WRE;
            end
            S_UP_WRE: begin
                cmd.cap_b     = 1'b1;
                cmd.mat_we    = 1'b1;
                cmd.wr_sel    = cma_pkg::ADDR_RC;
                cmd.wdata_sel = cma_pkg::WD_RE;
                n_state = S_UP_WRI;
            end
            S_UP_WRI: begin
                // diagonal carries no imaginary part
                cmd.mat_we    = (r_row != r_col);
                cmd.wr_sel    = cma_pkg::ADDR_CR;
                cmd.wdata_sel = cma_pkg::WD_IM;
                if (r_col == fcnt) begin
                    if ((r_row + cma_pkg::IdxW'(1)) == fcnt) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = r_row + cma_pkg::IdxW'(1);
                        n_col   = r_row + cma_pkg::IdxW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_col   = r_col + cma_pkg::IdxW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_DM_RD: begin
                cmd.rd_sel = cma_pkg::ADDR_SWEEP;
                n_state = S_DM_MUL;
            end
            S_DM_MUL: begin
                cmd.damp_load = 1'b1;
                n_state = S_DM_WR;
            end
            S_DM_WR: begin
                cmd.mat_we    = 1'b1;
                cmd.wr_sel    = cma_pkg::ADDR_SWEEP;
                cmd.wdata_sel = cma_pkg::WD_DAMP;
                if (r_sweep == LastEntry) begin
                    n_sweep = '0;
                    n_state = S_DONE;
                end else begin
                    n_sweep = r_sweep + cma_pkg::SweepW'(1);
                    n_state = S_DM_RD;
                end
            end
            S_RD: begin
                cmd.rd_sel = cma_pkg::ADDR_RC;
                n_state = S_RDL;
            end
            S_RDL: begin
                cmd.cap_val = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set, hold or drop the result flag
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_sweep     <= '0;
            r_kind      <= cma_pkg::KIND_UPDATE;
            r_oob       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_sweep     <= n_sweep;
            r_kind      <= n_kind;
            r_oob       <= n_oob;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_INIT)
        else $error("reset does not start the clearing pass");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while held");
    a_upper_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD) |-> (r_col >= r_row) && (r_col <= fcnt))
        else $error("update column outside the triangle");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cmd.mat_we)
        else $error("matrix written while idle");
`endif

endmodule

// ===== design/cma_datapath.sv =====
// ----------------------------------------------------------------------------
// cma_datapath
// Datapath: vector buffer, matrix memory, products, saturating accumulate,
// damping and the result register.
// ----------------------------------------------------------------------------
module cma_datapath #(
    parameter int MAX_FEATURES = cma_pkg::MaxFeatures,
    parameter int SAMPLE_WIDTH = cma_pkg::SampleWidth,
    parameter int ACC_WIDTH    = cma_pkg::AccWidth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cma_pkg::CfgWidth-1:0]        i_cfg_data,
    input  logic [cma_pkg::PortIdxW-1:0]        i_element_index,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_im,
    input  logic [cma_pkg::DampWidth-1:0]       i_damping_factor,
    input  cma_pkg::t_cmd                       i_cmd,
    output cma_pkg::t_status                    o_status,
    output logic [cma_pkg::OpWidth-1:0]         o_result_kind,
    output logic signed [ACC_WIDTH-1:0]         o_entry_value
);

    localparam int Dim   = MAX_FEATURES + 1;
    localparam int VecAw = $clog2(Dim);
    localparam int MatAw = $clog2(Dim * Dim);
    localparam int VecW  = 2 * SAMPLE_WIDTH;
    localparam int PrW   = 2 * SAMPLE_WIDTH;
    localparam int PsW   = PrW + 1;
    localparam int SumW  = ((ACC_WIDTH > PsW) ? ACC_WIDTH : PsW) + 1;
    localparam int LoW   = ACC_WIDTH / 2;
    localparam int HiW   = ACC_WIDTH - LoW;
    localparam int ProdW = ACC_WIDTH + cma_pkg::DampWidth + 1;
    localparam logic [cma_pkg::IdxW-1:0] MaxIdx = cma_pkg::IdxW'(MAX_FEATURES);
    localparam logic signed [SumW-1:0] SumMax =
        $signed({{(SumW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
    localparam logic signed [SumW-1:0] SumMin = -SumMax - SumW'(1);
    localparam logic [ProdW-1:0] PosLim = {{(ProdW - ACC_WIDTH + 1){1'b0}},
                                           {(ACC_WIDTH - 1){1'b1}}};
    localparam logic [ProdW-1:0] NegLim = PosLim + ProdW'(1);
    localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (cma_pkg::DampFrac - 1);

    // Configuration register
    logic [cma_pkg::CfgWidth-1:0] r_fc;
    logic [cma_pkg::IdxW-1:0]     fc_ext, eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= cma_pkg::FeatureCountReset;
        end else if (i_cfg_valid) begin
            r_fc <= i_cfg_data;
        end
    end

    // Clamp the count into one to the maximum
    assign fc_ext = {1'b0, r_fc};
    always_comb begin
        if (r_fc == '0) begin
            eff = cma_pkg::IdxW'(1);
        end else if (fc_ext > MaxIdx) begin
            eff = MaxIdx;
        end else begin
            eff = fc_ext;
        end
    end
    assign o_status.feature_count = eff;

    // Vector buffer
    logic [cma_pkg::IdxW-1:0] widx_ext, vec_ridx;
    logic [VecW-1:0]          vec_rdata;

    assign widx_ext = {1'b0, i_element_index};
    assign vec_ridx = i_cmd.vec_rd_row ? i_cmd.row : i_cmd.col;

    cma_ram #(.WIDTH(VecW), .DEPTH(Dim)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vec_we),
        .i_waddr (widx_ext[VecAw-1:0]),
        .i_wdata ({i_sample_re, i_sample_im}),
        .i_raddr (vec_ridx[VecAw-1:0]),
        .o_rdata (vec_rdata)
    );

    logic signed [SAMPLE_WIDTH-1:0] xc_re, xc_im;
    assign xc_re = $signed(vec_rdata[VecW-1:SAMPLE_WIDTH]);
    assign xc_im = $signed(vec_rdata[SAMPLE_WIDTH-1:0]);

    // Matrix memory addressing
    function automatic logic [MatAw-1:0] mat_addr(
        input logic [1:0]                 sel,
        input logic [cma_pkg::IdxW-1:0]   row,
        input logic [cma_pkg::IdxW-1:0]   col,
        input logic [cma_pkg::SweepW-1:0] sweep
    );
        logic [MatAw-1:0] a;
        case (sel)
            cma_pkg::ADDR_RC:    a = MatAw'(row) * MatAw'(Dim) + MatAw'(col);
            cma_pkg::ADDR_CR:    a = MatAw'(col) * MatAw'(Dim) + MatAw'(row);
            cma_pkg::ADDR_SWEEP: a = sweep[MatAw-1:0];
            default:             a = '0;
        endcase
        return a;
    endfunction

    // Saturating accumulate of a product sum
    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [PsW-1:0]       p
    );
        logic signed [SumW-1:0] s;
        logic signed [ACC_WIDTH-1:0] res;
        s = SumW'(a) + SumW'(p);
        if (s > SumMax) begin
            res = SumMax[ACC_WIDTH-1:0];
        end else if (s < SumMin) begin
            res = SumMin[ACC_WIDTH-1:0];
        end else begin
            res = s[ACC_WIDTH-1:0];
        end
        return res;
    endfunction

    logic signed [ACC_WIDTH-1:0] mat_rdata, mat_wdata;

    // Row element, products and captured matrix reads
    logic signed [SAMPLE_WIDTH-1:0] r_xr_re, r_xr_im;
    logic signed [PrW-1:0]          r_p0, r_p1, r_p2, r_p3;
    logic signed [ACC_WIDTH-1:0]    r_a, r_b, r_val;
    logic signed [PsW-1:0]          p_re, p_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.xr_load) begin
            r_xr_re <= xc_re;
            r_xr_im <= xc_im;
        end
        if (i_cmd.prod_load) begin
            r_p0 <= r_xr_re * xc_re;
            r_p1 <= r_xr_im * xc_im;
            r_p2 <= r_xr_re * xc_im;
            r_p3 <= r_xr_im * xc_re;
        end
        if (i_cmd.cap_a) begin
            r_a <= mat_rdata;
        end
        if (i_cmd.cap_b) begin
            r_b <= mat_rdata;
        end
        if (i_cmd.cap_val) begin
            r_val <= mat_rdata;
        end
    end

    assign p_re = PsW'(r_p0) + PsW'(r_p1);
    assign p_im = PsW'(r_p2) - PsW'(r_p3);

    // Damping: magnitude split into two halves times the factor
    logic [cma_pkg::DampWidth-1:0] r_damp;
    logic [LoW+cma_pkg::DampWidth-1:0] r_pl;
    logic [HiW+cma_pkg::DampWidth-1:0] r_ph;
    logic                              r_neg;
    logic [ACC_WIDTH-1:0]              mag;
    logic [ProdW-1:0]                  dprod, dq, dlim, dsat;
    logic [ACC_WIDTH-1:0]              dmag;
    logic signed [ACC_WIDTH-1:0]       damped;

    assign mag = mat_rdata[ACC_WIDTH-1] ? (~mat_rdata + ACC_WIDTH'(1)) : mat_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.damp_cap) begin
            r_damp <= i_damping_factor;
        end
        if (i_cmd.damp_load) begin
            r_pl  <= mag[LoW-1:0] * r_damp;
            r_ph  <= mag[ACC_WIDTH-1:LoW] * r_damp;
            r_neg <= mat_rdata[ACC_WIDTH-1];
        end
    end

    // Round half away from zero, then saturate
    assign dprod  = (ProdW'(r_ph) << LoW) + ProdW'(r_pl);
    assign dq     = (dprod + RoundHalf) >> cma_pkg::DampFrac;
    assign dlim   = r_neg ? NegLim : PosLim;
    assign dsat   = (dq > dlim) ? dlim : dq;
    assign dmag   = dsat[ACC_WIDTH-1:0];
    assign damped = r_neg ? $signed(~dmag + ACC_WIDTH'(1)) : $signed(dmag);

    // Select write data
    always_comb begin
        case (i_cmd.wdata_sel)
            cma_pkg::WD_RE:   mat_wdata = sat_add(r_a, p_re);
            cma_pkg::WD_IM:   mat_wdata = sat_add(r_b, p_im);
            cma_pkg::WD_DAMP: mat_wdata = damped;
            default:          mat_wdata = '0;
        endcase
    end

    cma_ram #(.WIDTH(ACC_WIDTH), .DEPTH(Dim * Dim)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mat_we),
        .i_waddr (mat_addr(i_cmd.wr_sel, i_cmd.row, i_cmd.col, i_cmd.sweep)),
        .i_wdata (mat_wdata),
        .i_raddr (mat_addr(i_cmd.rd_sel, i_cmd.row, i_cmd.col, i_cmd.sweep)),
        .o_rdata (mat_rdata)
    );

    // Result register
    logic [cma_pkg::OpWidth-1:0] r_kind_out;
    logic signed [ACC_WIDTH-1:0] r_value_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind_out  <= i_cmd.kind;
            r_value_out <= i_cmd.out_zero ? '0 : r_val;
        end
    end

    assign o_result_kind = r_kind_out;
    assign o_entry_value = r_value_out;

endmodule
